[sv/hrbd_pkg.sv]
package hrbd_pkg;

  localparam int LINE_LIMIT_DEF  = 4096;
  localparam int LENGTH_BITS_DEF = 48;
  localparam int REM_W           = 64;
  localparam int OUT_LEN_W       = 48;
  localparam int PDATA_W         = 64;
  localparam int PADDR_W         = 4;
  localparam int REG_IDX_W       = PADDR_W - 3;

  localparam logic [REG_IDX_W-1:0] REG_MAX_CHUNK = '0;
  localparam logic [OUT_LEN_W-1:0] MAX_CHUNK_RST = 48'd1073741824;
  localparam logic [OUT_LEN_W-1:0] OUT_LEN_MAX   = '1;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_C  = 8'h63;

  localparam logic [8*5-1:0]  PAT_HTTP  = "HTTP/";
  localparam logic [8*15-1:0] PAT_CLEN  = "content-length:";
  localparam logic [8*18-1:0] PAT_TENC  = "transfer-encoding:";
  localparam logic [8*7-1:0]  PAT_CHUNK = "chunked";
  localparam logic [4:0] CLEN_LEN = 5'd15;
  localparam logic [4:0] TENC_LEN = 5'd18;

  typedef enum logic [3:0] {
    PH_STATUS, PH_STATUS_TAIL, PH_NAME, PH_CLEN, PH_TENC, PH_SKIP, PH_NUL,
    PH_CSIZE, PH_CDATA, PH_CEND, PH_TRAIL, PH_COUNTED, PH_TO_CLOSE, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE, EV_HDR_OK, EV_BODY_DONE, EV_ERROR
  } ev_t;

  typedef enum logic [2:0] {
    ERR_NONE, ERR_CLOSED_HDR, ERR_BAD_STATUS, ERR_BAD_SIZE,
    ERR_TOO_LARGE, ERR_LINE_LONG, ERR_EARLY_END
  } err_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic                 payload_valid;
    logic [7:0]           payload_byte;
    logic [1:0]           event_res;
    logic [2:0]           error_kind;
    logic [9:0]           status_num;
    logic                 is_chunked;
    logic                 length_known;
    logic [OUT_LEN_W-1:0] declared_length;
  } res_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_dig(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [7:0] t;
    t = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      t = b - 8'h30;
      return {1'b1, t[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      t = b - 8'h57;
      return {1'b1, t[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      t = b - 8'h37;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
  endfunction

  function automatic logic [7:0] http_at(input logic [2:0] i);
    int k;
    k = 4 - int'(i);
    if (i < 3'd5) return PAT_HTTP[8*k +: 8];
    return 8'h00;
  endfunction

  function automatic logic [7:0] clen_at(input logic [4:0] i);
    int k;
    k = 14 - int'(i);
    if (i < CLEN_LEN) return PAT_CLEN[8*k +: 8];
    return 8'h00;
  endfunction

  function automatic logic [7:0] tenc_at(input logic [4:0] i);
    int k;
    k = 17 - int'(i);
    if (i < TENC_LEN) return PAT_TENC[8*k +: 8];
    return 8'h00;
  endfunction

  function automatic logic [7:0] chunk_at(input logic [2:0] i);
    int k;
    k = 6 - int'(i);
    if (i < 3'd7) return PAT_CHUNK[8*k +: 8];
    return 8'h00;
  endfunction

endpackage

[sv/hrbd_if.sv]
interface hrbd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink (input valid, action, data_byte, output ready);
endinterface

interface hrbd_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [1:0]  event_res;
  logic [2:0]  error_kind;
  logic [9:0]  status_num;
  logic        is_chunked;
  logic        length_known;
  logic [47:0] declared_length;
  modport source (output valid, payload_valid, payload_byte, event_res, error_kind,
                  status_num, is_chunked, length_known, declared_length,
                  input ready);
  modport sink (input valid, payload_valid, payload_byte, event_res, error_kind,
                status_num, is_chunked, length_known, declared_length,
                output ready);
endinterface

[sv/hrbd_cfg.sv]
module hrbd_cfg (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [hrbd_pkg::PADDR_W-1:0]          paddr,
  input  logic [hrbd_pkg::PDATA_W-1:0]          pwdata,
  output logic [hrbd_pkg::PDATA_W-1:0]          prdata,
  output logic                                  pready,
  output logic [hrbd_pkg::OUT_LEN_W-1:0]        max_chunk
);
  logic [hrbd_pkg::OUT_LEN_W-1:0] max_chunk_r;
  logic [hrbd_pkg::REG_IDX_W-1:0] idx;
  logic                           wr_en;

  assign idx   = paddr[hrbd_pkg::PADDR_W-1:3];
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && (idx == hrbd_pkg::REG_MAX_CHUNK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chunk_r <= hrbd_pkg::MAX_CHUNK_RST;
    end else if (wr_en) begin
      max_chunk_r <= pwdata[hrbd_pkg::OUT_LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx == hrbd_pkg::REG_MAX_CHUNK) begin
      prdata = hrbd_pkg::PDATA_W'(max_chunk_r);
    end
  end

  assign max_chunk = max_chunk_r;
endmodule

[sv/hrbd_parser.sv]
module hrbd_parser #(
  parameter int LINE_LIMIT  = hrbd_pkg::LINE_LIMIT_DEF,
  parameter int LENGTH_BITS = hrbd_pkg::LENGTH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  hrbd_pkg::in_item_t             item,
  input  logic [hrbd_pkg::OUT_LEN_W-1:0] max_chunk,
  output hrbd_pkg::res_t                 res
);
  localparam int LL_W = $clog2(LINE_LIMIT);
  localparam int LB   = LENGTH_BITS;
  localparam int RW   = hrbd_pkg::REM_W;

  hrbd_pkg::phase_t ph_r, ph_nxt;
  logic [1:0]      tm_r, tm_nxt;
  logic [LL_W-1:0] ll_r, ll_nxt;
  logic [4:0]      hp_r, hp_nxt;
  logic [1:0]      hc_r, hc_nxt;
  logic [2:0]      wp_r, wp_nxt;
  logic [2:0]      ss_r, ss_nxt;
  logic [9:0]      sv_r, sv_nxt;
  logic [LB-1:0]   lv_r, lv_nxt;
  logic [RW-1:0]   rb_r, rb_nxt;
  logic            cf_r, cf_nxt, lf_r, lf_nxt, ds_r, ds_nxt, le_r, le_nxt, sn_r, sn_nxt;
  logic [1:0]      ev;
  logic [2:0]      kd;
  logic            pv;

  logic [7:0]      b;
  logic [3:0]      dig;
  logic [4:0]      hx;
  logic [13:0]     sv_mac;
  logic [9:0]      sv_sat;
  logic [LB+3:0]   lv_mac;
  logic [LB-1:0]   lv_sat;
  logic [RW-1:0]   rb_hex, rb_neg, rb_dec;
  logic [LL_W-1:0] ll_inc;
  logic [63:0]     lv64;

  assign b      = item.data_byte;
  assign dig    = b[3:0];
  assign hx     = hrbd_pkg::hex_val(b);
  assign sv_mac = 14'({sv_r, 3'b000}) + 14'({sv_r, 1'b0}) + 14'(dig);
  assign sv_sat = (sv_mac > 14'd999) ? 10'd999 : sv_mac[9:0];
  assign lv_mac = (LB+4)'({lv_r, 3'b000}) + (LB+4)'({lv_r, 1'b0}) + (LB+4)'(dig);
  assign lv_sat = (lv_mac[LB+3:LB] != 4'd0) ? '1 : lv_mac[LB-1:0];
  assign rb_hex = (rb_r[RW-1:RW-4] != 4'd0) ? '1 : {rb_r[RW-5:0], hx[3:0]};
  assign rb_neg = (sn_r && (rb_r != '1)) ? (RW'(0) - rb_r) : rb_r;
  assign rb_dec = (rb_r != '0) ? rb_r - RW'(1) : '0;
  assign ll_inc = ll_r + LL_W'(1);

  always_comb begin : next_state
    logic hend, tohex, skip;
    hend = 1'b0; tohex = 1'b0; skip = 1'b0;
    ph_nxt = ph_r; tm_nxt = tm_r; ll_nxt = ll_r; hp_nxt = hp_r; hc_nxt = hc_r;
    wp_nxt = wp_r; ss_nxt = ss_r; sv_nxt = sv_r; lv_nxt = lv_r; rb_nxt = rb_r;
    cf_nxt = cf_r; lf_nxt = lf_r; ds_nxt = ds_r; le_nxt = le_r; sn_nxt = sn_r;
    ev = hrbd_pkg::EV_NONE; kd = hrbd_pkg::ERR_NONE; pv = 1'b0;
    if (item.action) begin
      if (ph_r <= hrbd_pkg::PH_NUL) begin
        ev = hrbd_pkg::EV_ERROR; kd = hrbd_pkg::ERR_CLOSED_HDR;
      end else if (ph_r == hrbd_pkg::PH_TO_CLOSE) begin
        ev = hrbd_pkg::EV_BODY_DONE;
      end else if (ph_r != hrbd_pkg::PH_DONE) begin
        ev = hrbd_pkg::EV_ERROR; kd = hrbd_pkg::ERR_EARLY_END;
      end
      ph_nxt = hrbd_pkg::PH_DONE;
    end else if (ph_r <= hrbd_pkg::PH_NUL) begin
      // blank line detector runs on every header byte
      if (b == hrbd_pkg::CH_CR) begin
        tm_nxt = (tm_r == 2'd2) ? 2'd3 : 2'd1;
      end else if (b == hrbd_pkg::CH_LF) begin
        hend = (tm_r == 2'd3);
        tm_nxt = (tm_r == 2'd1) ? 2'd2 : 2'd0;
      end else begin
        tm_nxt = 2'd0;
      end
      if (ph_r != hrbd_pkg::PH_NUL) begin
        if (b == hrbd_pkg::CH_CR || b == hrbd_pkg::CH_LF || b == hrbd_pkg::CH_NUL) begin
          skip = (ph_r == hrbd_pkg::PH_STATUS) && (ss_r == 3'd0);
          if (!skip) begin
            if (ph_r == hrbd_pkg::PH_STATUS && !(ss_r == 3'd7 && ds_r)) begin
              ss_nxt = 3'd0; ds_nxt = 1'b0;
            end
            ph_nxt = hrbd_pkg::PH_NAME; hp_nxt = 5'd0; hc_nxt = 2'b11; wp_nxt = 3'd0;
          end
          if (b == hrbd_pkg::CH_NUL) ph_nxt = hrbd_pkg::PH_NUL;
        end else if (ph_r == hrbd_pkg::PH_STATUS) begin
          if (ss_r < 3'd5) begin
            if (b == hrbd_pkg::http_at(ss_r)) begin
              ss_nxt = ss_r + 3'd1; ds_nxt = 1'b0;
            end else begin
              ss_nxt = 3'd0; ds_nxt = 1'b0; ph_nxt = hrbd_pkg::PH_STATUS_TAIL;
            end
          end else if (ss_r == 3'd5) begin
            if (!hrbd_pkg::is_ws(b)) ds_nxt = 1'b1;
            else if (ds_r) begin
              ss_nxt = 3'd6; ds_nxt = 1'b0;
            end
          end else if (ss_r == 3'd6) begin
            if (hrbd_pkg::is_ws(b)) begin
              ss_nxt = ss_r;
            end else if (b == hrbd_pkg::CH_PLUS || b == hrbd_pkg::CH_MINUS) begin
              sn_nxt = (b == hrbd_pkg::CH_MINUS); ss_nxt = 3'd7;
            end else if (hrbd_pkg::is_dig(b)) begin
              ss_nxt = 3'd7; ds_nxt = 1'b1;
              if (!sn_r) sv_nxt = sv_sat;
            end else begin
              ss_nxt = 3'd0; ds_nxt = 1'b0; ph_nxt = hrbd_pkg::PH_STATUS_TAIL;
            end
          end else begin
            if (hrbd_pkg::is_dig(b)) begin
              ds_nxt = 1'b1;
              if (!sn_r) sv_nxt = sv_sat;
            end else if (ds_r) begin
              ph_nxt = hrbd_pkg::PH_STATUS_TAIL;
            end else begin
              ss_nxt = 3'd0; ds_nxt = 1'b0; ph_nxt = hrbd_pkg::PH_STATUS_TAIL;
            end
          end
        end else if (ph_r == hrbd_pkg::PH_NAME) begin
          hc_nxt = hc_r;
          if (hc_r[0] && (hp_r >= hrbd_pkg::CLEN_LEN ||
                          hrbd_pkg::to_lower(b) != hrbd_pkg::clen_at(hp_r))) hc_nxt[0] = 1'b0;
          if (hc_r[1] && (hp_r >= hrbd_pkg::TENC_LEN ||
                          hrbd_pkg::to_lower(b) != hrbd_pkg::tenc_at(hp_r))) hc_nxt[1] = 1'b0;
          hp_nxt = hp_r + 5'd1;
          if (hc_nxt[0] && hp_nxt == hrbd_pkg::CLEN_LEN) begin
            ph_nxt = hrbd_pkg::PH_CLEN; lf_nxt = 1'b1; lv_nxt = '0; wp_nxt = 3'd0;
          end else if (hc_nxt[1] && hp_nxt == hrbd_pkg::TENC_LEN) begin
            ph_nxt = hrbd_pkg::PH_TENC; wp_nxt = 3'd0;
          end else if (hc_nxt == 2'b00) begin
            ph_nxt = hrbd_pkg::PH_SKIP;
          end
        end else if (ph_r == hrbd_pkg::PH_CLEN) begin
          // 0 lead, 1 digits, 2 negative digits, 3 stopped
          if (wp_r == 3'd0) begin
            if (hrbd_pkg::is_ws(b)) wp_nxt = 3'd0;
            else if (b == hrbd_pkg::CH_PLUS) wp_nxt = 3'd1;
            else if (b == hrbd_pkg::CH_MINUS) wp_nxt = 3'd2;
            else if (!hrbd_pkg::is_dig(b)) wp_nxt = 3'd3;
            else begin
              wp_nxt = 3'd1; lv_nxt = lv_sat;
            end
          end else if (wp_r == 3'd1 && hrbd_pkg::is_dig(b)) begin
            lv_nxt = lv_sat;
          end else if (!(wp_r == 3'd2 && hrbd_pkg::is_dig(b))) begin
            wp_nxt = 3'd3;
          end
        end else if (ph_r == hrbd_pkg::PH_TENC) begin
          if (wp_r < 3'd7 && b == hrbd_pkg::chunk_at(wp_r)) begin
            if (wp_r == 3'd6) begin
              cf_nxt = 1'b1; wp_nxt = 3'd0;
            end else begin
              wp_nxt = wp_r + 3'd1;
            end
          end else begin
            wp_nxt = (b == hrbd_pkg::CH_LC_C) ? 3'd1 : 3'd0;
          end
        end
      end
      if (hend) begin
        if (!(ss_nxt == 3'd7 && ds_nxt)) begin
          ev = hrbd_pkg::EV_ERROR; kd = hrbd_pkg::ERR_BAD_STATUS; ph_nxt = hrbd_pkg::PH_DONE;
        end else begin
          ll_nxt = '0; le_nxt = 1'b1; ds_nxt = 1'b0; sn_nxt = 1'b0; wp_nxt = 3'd0;
          rb_nxt = '0;
          ev = hrbd_pkg::EV_HDR_OK;
          if (cf_nxt) begin
            ph_nxt = hrbd_pkg::PH_CSIZE;
          end else if (lf_nxt) begin
            rb_nxt = RW'(lv_r);
            if (lv_r == '0) begin
              ev = hrbd_pkg::EV_BODY_DONE; ph_nxt = hrbd_pkg::PH_DONE;
            end else begin
              ph_nxt = hrbd_pkg::PH_COUNTED;
            end
          end else begin
            ph_nxt = hrbd_pkg::PH_TO_CLOSE;
          end
        end
      end
    end else if (ph_r == hrbd_pkg::PH_CSIZE || ph_r == hrbd_pkg::PH_CEND ||
                 ph_r == hrbd_pkg::PH_TRAIL) begin
      if (b != hrbd_pkg::CH_LF) begin
        ll_nxt = ll_inc;
        le_nxt = (ll_inc == LL_W'(1)) && (b == hrbd_pkg::CH_CR);
        if (ll_inc >= LL_W'(LINE_LIMIT - 1)) begin
          ev = hrbd_pkg::EV_ERROR; kd = hrbd_pkg::ERR_LINE_LONG; ph_nxt = hrbd_pkg::PH_DONE;
        end else if (ph_r == hrbd_pkg::PH_CSIZE) begin
          // size scan: 0 lead, 1 after sign, 2 after 0, 3 after 0x, 4 digits, 5 stopped
          unique case (wp_r)
            3'd0: begin
              if (hrbd_pkg::is_ws(b)) begin
                wp_nxt = 3'd0;
              end else if (b == hrbd_pkg::CH_PLUS || b == hrbd_pkg::CH_MINUS) begin
                sn_nxt = (b == hrbd_pkg::CH_MINUS); wp_nxt = 3'd1;
              end else if (b == hrbd_pkg::CH_ZERO) begin
                ds_nxt = 1'b1; wp_nxt = 3'd2;
              end else tohex = 1'b1;
            end
            3'd1: begin
              if (b == hrbd_pkg::CH_ZERO) begin
                ds_nxt = 1'b1; wp_nxt = 3'd2;
              end else tohex = 1'b1;
            end
            3'd2: begin
              if (b == hrbd_pkg::CH_LC_X || b == hrbd_pkg::CH_UC_X) wp_nxt = 3'd3;
              else tohex = 1'b1;
            end
            3'd3, 3'd4: tohex = 1'b1;
            default: tohex = 1'b0;
          endcase
          if (tohex) begin
            if (!hx[4]) begin
              wp_nxt = 3'd5;
            end else begin
              ds_nxt = 1'b1; wp_nxt = 3'd4; rb_nxt = rb_hex;
            end
          end
        end
      end else if (ph_r == hrbd_pkg::PH_CSIZE) begin
        if (!ds_r) begin
          ev = hrbd_pkg::EV_ERROR; kd = hrbd_pkg::ERR_BAD_SIZE; ph_nxt = hrbd_pkg::PH_DONE;
        end else begin
          ll_nxt = '0; le_nxt = 1'b1; ds_nxt = 1'b0; sn_nxt = 1'b0; wp_nxt = 3'd0;
          rb_nxt = '0;
          if (rb_neg == '0) begin
            ph_nxt = hrbd_pkg::PH_TRAIL;
          end else if (rb_neg > RW'(max_chunk)) begin
            ev = hrbd_pkg::EV_ERROR; kd = hrbd_pkg::ERR_TOO_LARGE; ph_nxt = hrbd_pkg::PH_DONE;
          end else begin
            rb_nxt = rb_neg; ph_nxt = hrbd_pkg::PH_CDATA;
          end
        end
      end else if (ph_r == hrbd_pkg::PH_CEND) begin
        ll_nxt = '0; le_nxt = 1'b1; ds_nxt = 1'b0; sn_nxt = 1'b0; wp_nxt = 3'd0;
        rb_nxt = '0; ph_nxt = hrbd_pkg::PH_CSIZE;
      end else if (le_r) begin
        ev = hrbd_pkg::EV_BODY_DONE; ph_nxt = hrbd_pkg::PH_DONE;
      end else begin
        ll_nxt = '0; le_nxt = 1'b1; ds_nxt = 1'b0; sn_nxt = 1'b0; wp_nxt = 3'd0;
        rb_nxt = '0;
      end
    end else if (ph_r == hrbd_pkg::PH_CDATA || ph_r == hrbd_pkg::PH_COUNTED) begin
      pv = 1'b1;
      rb_nxt = rb_dec;
      if (rb_dec == '0) begin
        if (ph_r == hrbd_pkg::PH_COUNTED) begin
          ev = hrbd_pkg::EV_BODY_DONE; ph_nxt = hrbd_pkg::PH_DONE;
        end else begin
          ll_nxt = '0; le_nxt = 1'b1; ds_nxt = 1'b0; sn_nxt = 1'b0; wp_nxt = 3'd0;
          ph_nxt = hrbd_pkg::PH_CEND;
        end
      end
    end else if (ph_r == hrbd_pkg::PH_TO_CLOSE) begin
      pv = 1'b1;
    end
  end

  assign lv64 = 64'(lv_nxt);

  always_comb begin : result
    res.payload_valid   = pv;
    res.payload_byte    = pv ? b : 8'h00;
    res.event_res       = ev;
    res.error_kind      = kd;
    res.status_num      = sv_nxt;
    res.is_chunked      = cf_nxt;
    res.length_known    = lf_nxt;
    res.declared_length = (lv64 > 64'(hrbd_pkg::OUT_LEN_MAX)) ? hrbd_pkg::OUT_LEN_MAX
                                                              : lv64[hrbd_pkg::OUT_LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= hrbd_pkg::PH_STATUS;
      tm_r <= '0; ll_r <= '0; hp_r <= '0; hc_r <= 2'b11; wp_r <= '0; ss_r <= '0;
      sv_r <= '0; lv_r <= '0; rb_r <= '0;
      cf_r <= 1'b0; lf_r <= 1'b0; ds_r <= 1'b0; le_r <= 1'b1; sn_r <= 1'b0;
    end else if (step) begin
      ph_r <= ph_nxt;
      tm_r <= tm_nxt; ll_r <= ll_nxt; hp_r <= hp_nxt; hc_r <= hc_nxt; wp_r <= wp_nxt;
      ss_r <= ss_nxt; sv_r <= sv_nxt; lv_r <= lv_nxt; rb_r <= rb_nxt;
      cf_r <= cf_nxt; lf_r <= lf_nxt; ds_r <= ds_nxt; le_r <= le_nxt; sn_r <= sn_nxt;
    end
  end
endmodule

[sv/http_response_body_deframer.sv]
// HTTP/1.x response body deframer.
// in_ch carries one beat per received response byte (action 0) or a
// connection-closed marker (action 1). out_ch carries exactly one result beat
// per input beat: the body byte when payload_valid is set, an event code
// (headers accepted, body complete, error with error_kind), and the current
// status code, chunked flag and declared Content-Length.
// Chunked, counted and read-until-close bodies are handled; max_chunk_size is
// written through the APB port at byte address 0; the user must write it only
// while the block is idle; the block does not enforce this. Each beat taken
// from in_ch goes to the input register, its result to the result register,
// which drives out_ch.valid. Throughput is one beat per cycle while out_ch
// is not stalled, set by the single pass of the parser between those two
// registers. When the receiver stalls, the result register holds and one
// more beat is held in the input register; in_ch.ready then drops until
// out_ch moves. Synchronous active-low reset returns the parser to the status
// line, clears both valid flags and sets max_chunk_size to 2^30. After body
// complete or any error, further input beats give empty results until reset.
module http_response_body_deframer #(
  parameter int LINE_LIMIT  = hrbd_pkg::LINE_LIMIT_DEF,
  parameter int LENGTH_BITS = hrbd_pkg::LENGTH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  hrbd_in_if.sink                        in_ch,
  hrbd_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hrbd_pkg::PADDR_W-1:0]   paddr,
  input  logic [hrbd_pkg::PDATA_W-1:0]   pwdata,
  output logic [hrbd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  logic                           in_v_r, out_v_r, adv, in_take;
  hrbd_pkg::in_item_t             in_item_r, in_item;
  hrbd_pkg::res_t                 res, out_res_r;
  logic [hrbd_pkg::OUT_LEN_W-1:0] max_chunk;

  hrbd_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .max_chunk
  );

  hrbd_parser #(.LINE_LIMIT(LINE_LIMIT), .LENGTH_BITS(LENGTH_BITS)) u_parser (
    .clk, .rst_n, .step(adv), .item(in_item_r), .max_chunk, .res
  );

  assign in_item.action    = in_ch.action;
  assign in_item.data_byte = in_ch.data_byte;

  // parse when the result register is free or being emptied
  assign adv         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_v_r <= in_ch.valid;
      if (adv) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_item_r <= in_item;
    if (adv) out_res_r <= res;
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.payload_valid   = out_res_r.payload_valid;
  assign out_ch.payload_byte    = out_res_r.payload_byte;
  assign out_ch.event_res       = out_res_r.event_res;
  assign out_ch.error_kind      = out_res_r.error_kind;
  assign out_ch.status_num      = out_res_r.status_num;
  assign out_ch.is_chunked      = out_res_r.is_chunked;
  assign out_ch.length_known    = out_res_r.length_known;
  assign out_ch.declared_length = out_res_r.declared_length;

  a_kind_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_res_r.event_res != hrbd_pkg::EV_ERROR)
      |-> out_res_r.error_kind == hrbd_pkg::ERR_NONE)
    else $error("error kind without error event");

  a_payload_not_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.payload_valid |-> out_res_r.event_res != hrbd_pkg::EV_ERROR)
    else $error("payload beat carries an error");

  a_held_beat_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && out_v_r && !out_ch.ready |=> in_v_r && $stable(in_item_r))
    else $error("held input beat lost while output stalled");
endmodule
